>>> rtl/hms3_pkg.sv
// package: constants, types and arithmetic helpers of the 3x3 height-map smoothing core
`timescale 1ns / 1ps

package hms3_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int SAMPLE_BITS = 16;

    localparam int DIM_BITS       = 11;
    localparam int COL_BITS       = $clog2(MAX_WIDTH);
    localparam int ROW_BITS       = 11;
    localparam int COLSUM_BITS    = SAMPLE_BITS + 2;
    localparam int SUM_BITS       = SAMPLE_BITS + 4;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [DIM_BITS-1:0] DIM_MIN       = DIM_BITS'(2);
    localparam logic [DIM_BITS-1:0] WIDTH_MAX     = DIM_BITS'(MAX_WIDTH);
    localparam logic [DIM_BITS-1:0] HEIGHT_MAX    = DIM_BITS'(MAX_HEIGHT);
    localparam logic [DIM_BITS-1:0] DIM_RESET     = DIM_BITS'(1024);

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = CFG_INDEX_BITS'(1);

    // operation codes carried on s_tuser
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    // result queue
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

    // reciprocal division: q = (x * M) >> 24, exact for the dividend ranges used here
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_BITS  = 24;
    localparam logic [RECIP_BITS-1:0] RECIP_THIRD = RECIP_BITS'(5592406);
    localparam logic [RECIP_BITS-1:0] RECIP_NINTH = RECIP_BITS'(1864136);

    localparam logic [SUM_BITS-1:0] HALF_OF_4 = SUM_BITS'(2);
    localparam logic [SUM_BITS-1:0] HALF_OF_6 = SUM_BITS'(3);
    localparam logic [SUM_BITS-1:0] HALF_OF_9 = SUM_BITS'(4);

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [2:0][SAMPLE_BITS-1:0] column_t;

    typedef enum logic [1:0] {
        DIV_BY_4,
        DIV_BY_6,
        DIV_BY_9
    } div_sel_t;

    // position flags of the item held in the input stage
    typedef struct packed {
        logic first_row;
        logic top_ok;
        logic virt_row;
        logic last_col;
        logic col_ge1;
        logic col_ge2;
    } pos_ctrl_t;

    typedef struct packed {
        sample_t height;
        logic    last_in_run;
        logic    last_of_frame;
    } result_t;

    function automatic logic [COLSUM_BITS-1:0] col_sum(
        input column_t col,
        input logic    top_ok,
        input logic    bottom_ok
    );
        logic [COLSUM_BITS-1:0] s;
        s = COLSUM_BITS'(col[1]);
        if (top_ok) begin
            s = s + COLSUM_BITS'(col[0]);
        end
        if (bottom_ok) begin
            s = s + COLSUM_BITS'(col[2]);
        end
        return s;
    endfunction

    // rounded mean, halves up: (sum + d/2) / d for d of 4, 6 or 9
    function automatic sample_t mean_round(
        input logic [SUM_BITS-1:0] sum,
        input div_sel_t            sel
    );
        logic [SUM_BITS-1:0]            biased;
        logic [SUM_BITS-1:0]            dividend;
        logic [RECIP_BITS-1:0]          recip;
        logic [SUM_BITS+RECIP_BITS-1:0] prod;
        logic [SUM_BITS-1:0]            quot;
        biased   = sum + HALF_OF_4;
        dividend = '0;
        recip    = RECIP_THIRD;
        case (sel)
            DIV_BY_4: begin
                biased   = sum + HALF_OF_4;
                dividend = biased;
            end
            DIV_BY_6: begin
                biased   = sum + HALF_OF_6;
                dividend = biased >> 1;
                recip    = RECIP_THIRD;
            end
            DIV_BY_9: begin
                biased   = sum + HALF_OF_9;
                dividend = biased;
                recip    = RECIP_NINTH;
            end
            default: begin
                dividend = biased;
            end
        endcase
        prod = (SUM_BITS+RECIP_BITS)'(dividend) * (SUM_BITS+RECIP_BITS)'(recip);
        if (sel == DIV_BY_4) begin
            quot = dividend >> 2;
        end else begin
            quot = prod[RECIP_SHIFT +: SUM_BITS];
        end
        return quot[SAMPLE_BITS-1:0];
    endfunction

endpackage

>>> rtl/heightmap_mean_smoothing_3x3_core.sv
// top level: streaming 3x3 mean filter over a height map in raster order
`timescale 1ns / 1ps

// 3x3 box mean over a frame_width x frame_height height map sent in raster
// order, one request per clock unless stalled. Each result is the rounded
// mean (halves up) of a map position and its in-bounds neighbours, so corners
// divide by 4, edges by 6 and the interior by 9. Results trail the input by
// one row and one column; the sample that ends a row releases two results,
// and after the last map row one row of frame_width drain ticks (s_tuser high)
// flushes the bottom row, whose final result carries m_tuser. Drain ticks sent
// inside the map are taken and dropped; samples sent in the drain row count
// as drain ticks. Rate: one input request per cycle while the result queue
// has room; an input passes the line-buffer read, the window sums and the
// divide into the result queue before m_tvalid. The single result port
// keeps pace: a row-end request makes two results but the column-zero
// request makes none, so a map row yields frame_width results and the small
// result queue absorbs the pair. The two line buffers are single-write,
// registered-read rams read at the column counter as a request is taken;
// they need no clearing pass after reset. Frame size registers take effect
// on write and restart the frame; write them only while the block is idle.
module heightmap_mean_smoothing_3x3_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [hms3_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [hms3_pkg::DIM_BITS-1:0]        cfg_wdata,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [15:0]                          s_tdata,  // [15:0] sample_height
    input  logic                                 s_tuser,  // [0] operation
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [15:0]                          m_tdata,  // [15:0] smoothed_height
    output logic                                 m_tlast,
    output logic                                 m_tuser   // [0] last_of_frame
);

    // configuration registers
    logic [hms3_pkg::DIM_BITS-1:0] frame_width_reg;
    logic [hms3_pkg::DIM_BITS-1:0] frame_height_reg;
    logic [hms3_pkg::DIM_BITS-1:0] w_eff;
    logic [hms3_pkg::DIM_BITS-1:0] h_eff;
    logic                          cfg_hit;

    // scan position
    logic [hms3_pkg::COL_BITS-1:0] col_reg, col_next;
    logic [hms3_pkg::ROW_BITS-1:0] row_reg, row_next;
    logic                          virt_row;
    logic                          last_col;

    // input handshake
    logic in_accept;
    logic is_drain;
    logic in_load;

    // input stage
    logic                          s1_valid_reg, s1_valid_next;
    hms3_pkg::sample_t             s1_sample_reg;
    logic [hms3_pkg::COL_BITS-1:0] s1_col_reg;
    hms3_pkg::pos_ctrl_t           s1_ctrl_reg, s1_ctrl_in;
    logic                          s1_adv;

    // line buffers
    hms3_pkg::sample_t older_rd;
    hms3_pkg::sample_t prev_rd;

    // sliding window of the two previous columns
    hms3_pkg::column_t win0_reg;
    hms3_pkg::column_t win1_reg;
    hms3_pkg::column_t cur_col;

    // window sums
    logic                             bottom_ok;
    logic                             rows3;
    logic [hms3_pkg::COLSUM_BITS-1:0] sum_cur;
    logic [hms3_pkg::COLSUM_BITS-1:0] sum_w0;
    logic [hms3_pkg::COLSUM_BITS-1:0] sum_w1;
    logic [hms3_pkg::SUM_BITS-1:0]    sum_b;
    logic [hms3_pkg::SUM_BITS-1:0]    sum_a;
    logic                             has_a;
    logic                             has_b;
    hms3_pkg::div_sel_t               sel_a;
    hms3_pkg::div_sel_t               sel_b;

    // divide stage
    logic                          s2_valid_reg, s2_valid_next;
    logic [hms3_pkg::SUM_BITS-1:0] s2_sum_a_reg;
    logic [hms3_pkg::SUM_BITS-1:0] s2_sum_b_reg;
    hms3_pkg::div_sel_t            s2_sel_a_reg;
    hms3_pkg::div_sel_t            s2_sel_b_reg;
    logic                          s2_has_b_reg;
    logic                          s2_frame_end_reg;
    logic                          s2_ready;
    logic                          s2_push;
    hms3_pkg::result_t             entry_a;
    hms3_pkg::result_t             entry_b;

    // result queue
    hms3_pkg::result_t                  fifo_mem_reg [hms3_pkg::FIFO_DEPTH];
    logic [hms3_pkg::FIFO_PTR_BITS-1:0] head_reg, head_next;
    logic [hms3_pkg::FIFO_PTR_BITS-1:0] tail_reg, tail_next;
    logic [hms3_pkg::FIFO_PTR_BITS-1:0] tail_plus1;
    logic [hms3_pkg::FIFO_CNT_BITS-1:0] count_reg, count_next;
    logic [hms3_pkg::FIFO_CNT_BITS-1:0] count_after_pop;
    logic                               pop;
    logic                               room;

    // ---------------------------------------------------------------
    // configuration, clamped to the supported frame size
    // ---------------------------------------------------------------
    assign cfg_hit = cfg_wr_en && (cfg_index == hms3_pkg::REG_FRAME_WIDTH ||
                                   cfg_index == hms3_pkg::REG_FRAME_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= hms3_pkg::DIM_RESET;
            frame_height_reg <= hms3_pkg::DIM_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == hms3_pkg::REG_FRAME_WIDTH) begin
                frame_width_reg <= cfg_wdata;
            end
            if (cfg_index == hms3_pkg::REG_FRAME_HEIGHT) begin
                frame_height_reg <= cfg_wdata;
            end
        end
    end

    always_comb begin
        if (frame_width_reg < hms3_pkg::DIM_MIN) begin
            w_eff = hms3_pkg::DIM_MIN;
        end else if (frame_width_reg > hms3_pkg::WIDTH_MAX) begin
            w_eff = hms3_pkg::WIDTH_MAX;
        end else begin
            w_eff = frame_width_reg;
        end
        if (frame_height_reg < hms3_pkg::DIM_MIN) begin
            h_eff = hms3_pkg::DIM_MIN;
        end else if (frame_height_reg > hms3_pkg::HEIGHT_MAX) begin
            h_eff = hms3_pkg::HEIGHT_MAX;
        end else begin
            h_eff = frame_height_reg;
        end
    end

    // ---------------------------------------------------------------
    // input acceptance and scan position
    // ---------------------------------------------------------------
    assign virt_row  = row_reg >= h_eff;
    assign last_col  = ({1'b0, col_reg} == (w_eff - hms3_pkg::DIM_BITS'(1)));
    assign s_tready  = !s1_valid_reg || s1_adv;
    assign in_accept = s_tvalid && s_tready;
    assign is_drain  = (s_tuser == hms3_pkg::OP_DRAIN);
    // a drain tick inside the map is taken and dropped without effect
    assign in_load   = in_accept && !(is_drain && !virt_row);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit) begin
            col_next = '0;
            row_next = '0;
        end else if (in_load) begin
            if (last_col) begin
                col_next = '0;
                // the drain row wraps back to the top of the next frame
                row_next = virt_row ? '0 : row_reg + hms3_pkg::ROW_BITS'(1);
            end else begin
                col_next = col_reg + hms3_pkg::COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------------------------------------------------------
    // input stage: position flags; line buffers read in parallel
    // ---------------------------------------------------------------
    always_comb begin
        s1_ctrl_in.first_row = (row_reg == '0);
        s1_ctrl_in.top_ok    = (row_reg >= hms3_pkg::ROW_BITS'(2));
        s1_ctrl_in.virt_row  = virt_row;
        s1_ctrl_in.last_col  = last_col;
        s1_ctrl_in.col_ge1   = (col_reg != '0);
        s1_ctrl_in.col_ge2   = (col_reg >= hms3_pkg::COL_BITS'(2));
    end

    assign s1_adv        = s1_valid_reg && s2_ready;
    assign s1_valid_next = in_load || (s1_valid_reg && !s1_adv);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            // samples in the drain row are dropped and stand as zero
            s1_sample_reg <= virt_row ? '0 : s_tdata;
            s1_col_reg    <= col_reg;
            s1_ctrl_reg   <= s1_ctrl_in;
        end
    end

    // row r-2 buffer: takes the row r-1 sample as it is replaced
    hms3_ram #(
        .WIDTH (hms3_pkg::SAMPLE_BITS),
        .DEPTH (hms3_pkg::MAX_WIDTH)
    ) u_older_row (
        .aclk    (aclk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (prev_rd),
        .rd_en   (in_load),
        .rd_addr (col_reg),
        .rd_data (older_rd)
    );

    // row r-1 buffer
    hms3_ram #(
        .WIDTH (hms3_pkg::SAMPLE_BITS),
        .DEPTH (hms3_pkg::MAX_WIDTH)
    ) u_prev_row (
        .aclk    (aclk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (s1_sample_reg),
        .rd_en   (in_load),
        .rd_addr (col_reg),
        .rd_data (prev_rd)
    );

    // column top to bottom: row r-2, row r-1, row r
    always_comb begin
        cur_col[0] = older_rd;
        cur_col[1] = prev_rd;
        cur_col[2] = s1_sample_reg;
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            win1_reg <= win0_reg;
            win0_reg <= cur_col;
        end
    end

    // ---------------------------------------------------------------
    // window sums and divisor choice
    // ---------------------------------------------------------------
    assign bottom_ok = !s1_ctrl_reg.virt_row;
    assign rows3     = s1_ctrl_reg.top_ok && bottom_ok;

    assign sum_cur = hms3_pkg::col_sum(cur_col, s1_ctrl_reg.top_ok, bottom_ok);
    assign sum_w0  = hms3_pkg::col_sum(win0_reg, s1_ctrl_reg.top_ok, bottom_ok);
    assign sum_w1  = hms3_pkg::col_sum(win1_reg, s1_ctrl_reg.top_ok, bottom_ok);

    // right edge result uses only the last two columns
    assign sum_b = hms3_pkg::SUM_BITS'(sum_w0) + hms3_pkg::SUM_BITS'(sum_cur);
    assign sum_a = sum_b + (s1_ctrl_reg.col_ge2 ? hms3_pkg::SUM_BITS'(sum_w1)
                                                : '0);

    assign has_a = !s1_ctrl_reg.first_row && s1_ctrl_reg.col_ge1;
    assign has_b = !s1_ctrl_reg.first_row && s1_ctrl_reg.last_col;

    always_comb begin
        if (rows3 && s1_ctrl_reg.col_ge2) begin
            sel_a = hms3_pkg::DIV_BY_9;
        end else if (rows3 || s1_ctrl_reg.col_ge2) begin
            sel_a = hms3_pkg::DIV_BY_6;
        end else begin
            sel_a = hms3_pkg::DIV_BY_4;
        end
        sel_b = rows3 ? hms3_pkg::DIV_BY_6 : hms3_pkg::DIV_BY_4;
    end

    // ---------------------------------------------------------------
    // divide stage, pushes one or two results into the queue
    // ---------------------------------------------------------------
    assign pop             = m_tvalid && m_tready;
    assign count_after_pop = count_reg - hms3_pkg::FIFO_CNT_BITS'(pop);
    // always keep space for a pair
    assign room     = count_after_pop <= hms3_pkg::FIFO_CNT_BITS'(hms3_pkg::FIFO_DEPTH - 2);
    assign s2_push  = s2_valid_reg && room;
    assign s2_ready = !s2_valid_reg || room;

    // a stage-1 item with no result leaves the divide stage empty
    assign s2_valid_next = s1_adv ? (has_a || has_b) : (s2_valid_reg && !s2_push);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            s2_sum_a_reg     <= sum_a;
            s2_sum_b_reg     <= sum_b;
            s2_sel_a_reg     <= sel_a;
            s2_sel_b_reg     <= sel_b;
            s2_has_b_reg     <= has_b;
            s2_frame_end_reg <= s1_ctrl_reg.virt_row;
        end
    end

    // a row-end item always has both results, so the first is never absent
    always_comb begin
        entry_a.height        = hms3_pkg::mean_round(s2_sum_a_reg, s2_sel_a_reg);
        entry_a.last_in_run   = !s2_has_b_reg;
        entry_a.last_of_frame = 1'b0;
        entry_b.height        = hms3_pkg::mean_round(s2_sum_b_reg, s2_sel_b_reg);
        entry_b.last_in_run   = 1'b1;
        entry_b.last_of_frame = s2_frame_end_reg;
    end

    // ---------------------------------------------------------------
    // result queue
    // ---------------------------------------------------------------
    assign tail_plus1 = tail_reg + hms3_pkg::FIFO_PTR_BITS'(1);

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_after_pop;
        if (pop) begin
            head_next = head_reg + hms3_pkg::FIFO_PTR_BITS'(1);
        end
        if (s2_push) begin
            if (s2_has_b_reg) begin
                tail_next  = tail_reg + hms3_pkg::FIFO_PTR_BITS'(2);
                count_next = count_after_pop + hms3_pkg::FIFO_CNT_BITS'(2);
            end else begin
                tail_next  = tail_plus1;
                count_next = count_after_pop + hms3_pkg::FIFO_CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_push) begin
            fifo_mem_reg[tail_reg] <= entry_a;
            if (s2_has_b_reg) begin
                fifo_mem_reg[tail_plus1] <= entry_b;
            end
        end
    end

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = fifo_mem_reg[head_reg].height;
    assign m_tlast  = fifo_mem_reg[head_reg].last_in_run;
    assign m_tuser  = fifo_mem_reg[head_reg].last_of_frame;

`ifndef SYNTHESIS
    a_col_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, col_reg} < w_eff)
        else $error("column position beyond frame width");

    a_row_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg <= h_eff)
        else $error("row position beyond drain row");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= hms3_pkg::FIFO_CNT_BITS'(hms3_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_frame_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("frame end result not last of its request");

    a_pair_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_push && s2_has_b_reg) |=>
            count_reg >= hms3_pkg::FIFO_CNT_BITS'(2))
        else $error("result pair lost in queue");
`endif

endmodule

>>> rtl/hms3_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module hms3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
